FILE: rtl/core/olirs_pkg.sv
package olirs_pkg;

    localparam int CapacityDef  = 256;
    localparam int ElemWidthDef = 32;

    localparam logic [1:0] OpInsert = 2'd0;
    localparam logic [1:0] OpRemove = 2'd1;
    localparam logic [1:0] OpFind   = 2'd2;
    localparam logic [1:0] OpClear  = 2'd3;

    localparam logic [1:0] StOk       = 2'd0;
    localparam logic [1:0] StFull     = 2'd1;
    localparam logic [1:0] StRange    = 2'd2;
    localparam logic [1:0] StNotFound = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  position;
        logic [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] found_position;
        logic [8:0] entry_count;
    } t_out_item;

    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctrl;

endpackage

FILE: rtl/core/olirs_cell.sv
module olirs_cell #(
    parameter int IDX = 0,
    parameter int EW  = olirs_pkg::ElemWidthDef,
    parameter int PW  = 9
) (
    input  logic                   i_clk,
    input  olirs_pkg::t_cell_ctrl  i_ctrl,
    input  logic [PW-1:0]          i_pos,
    input  logic [EW-1:0]          i_val,
    input  logic [EW-1:0]          i_left,
    input  logic [EW-1:0]          i_right,
    output logic [EW-1:0]          o_data,
    output logic                   o_hit
);

    localparam logic [PW-1:0] MyIdx = PW'(IDX);

    logic [EW-1:0] r_data;
    logic [EW-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.ins) begin
            if (MyIdx == i_pos) begin
                n_data = i_val;
            end else if (MyIdx > i_pos) begin
                n_data = i_left;
            end
        end else if (i_ctrl.rem) begin
            if (MyIdx >= i_pos) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_hit  = (r_data == i_val);

endmodule

FILE: rtl/core/olirs_find_tree.sv
module olirs_find_tree #(
    parameter int CAPACITY = olirs_pkg::CapacityDef,
    parameter int IW       = $clog2(olirs_pkg::CapacityDef)
) (
    input  logic                i_clk,
    input  logic [CAPACITY-1:0] i_match,
    output logic                o_found,
    output logic [IW-1:0]       o_idx
);

    localparam int P = 1 << IW;

    logic          r_found [1:2*P-1];
    logic [IW-1:0] r_idx   [1:2*P-1];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < P; i++) begin
            if (i < CAPACITY) begin
                r_found[P+i] <= i_match[i];
            end else begin
                r_found[P+i] <= 1'b0;
            end
            r_idx[P+i] <= IW'(i);
        end
        for (int n = 1; n < P; n++) begin
            r_found[n] <= r_found[2*n] | r_found[2*n+1];
            r_idx[n]   <= r_found[2*n] ? r_idx[2*n] : r_idx[2*n+1];
        end
    end

    assign o_found = r_found[1];
    assign o_idx   = r_idx[1];

endmodule

FILE: rtl/core/ordered_list_insert_remove_search_top.sv
// Ordered list engine: a row of CAPACITY cells holds a packed list of values.
// Insert and remove shift the cells from the position on toward or away from
// a neighbor at once; clear only zeroes the entry count. The result sits in
// the output register right after the accepting edge, and the next item may be
// taken at the following edge. Find registers its key at the accepting edge, and
// every cell then compares it. The matches are registered at the leaves of the
// first-match tree, where the lowest index wins, and climb its registered levels.
// The result register loads once the root holds the answer and the output
// register is free, and no item is taken before then. An item is taken only while
// no find runs and the output register is empty or being read in the same cycle.
module ordered_list_insert_remove_search_top #(
    parameter int CAPACITY      = olirs_pkg::CapacityDef,
    parameter int ELEMENT_WIDTH = olirs_pkg::ElemWidthDef
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  olirs_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output olirs_pkg::t_out_item o_out_item
);

    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int PW   = (CW > 8) ? CW : 8;
    localparam int EW   = ELEMENT_WIDTH;
    localparam int Lat  = IW + 1;
    localparam int CntW = $clog2(Lat + 1);

    localparam logic StIdle   = 1'b0;
    localparam logic StSearch = 1'b1;

    localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

    logic                 r_state, n_state;
    logic [CntW-1:0]      r_cnt, n_cnt;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_out_valid, n_out_valid;
    olirs_pkg::t_out_item r_out, n_out;
    logic [EW-1:0]        r_key, n_key;

    logic                  w_in_acc;
    logic                  w_slot;
    olirs_pkg::t_cell_ctrl w_ctrl;
    logic [PW-1:0]         w_pos_raw;
    logic [PW-1:0]         w_cnt_ext;
    logic [PW-1:0]         w_pos_ins;
    logic [PW-1:0]         w_cell_pos;
    logic [EW-1:0]         w_in_val;
    logic [EW-1:0]         w_cell_val;
    logic [EW-1:0]         w_data [CAPACITY];
    logic [CAPACITY-1:0]   w_hit;
    logic [CAPACITY-1:0]   w_match;
    logic                  w_found;
    logic [IW-1:0]         w_found_idx;

    assign w_slot     = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == StIdle) && w_slot;
    assign w_in_acc   = i_in_valid && o_in_ready;

    assign w_in_val   = EW'(i_in_item.value);
    assign w_cell_val = (r_state == StSearch) ? r_key : w_in_val;
    assign w_pos_raw  = PW'(i_in_item.position);
    assign w_cnt_ext  = PW'(r_count);
    assign w_pos_ins  = (w_pos_raw > w_cnt_ext) ? w_cnt_ext : w_pos_raw;
    assign w_cell_pos = (i_in_item.opcode == olirs_pkg::OpInsert) ? w_pos_ins : w_pos_raw;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [EW-1:0] w_left;
            logic [EW-1:0] w_right;
            if (g == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_data[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_data[g+1];
            end
            olirs_cell #(
                .IDX (g),
                .EW  (EW),
                .PW  (PW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl),
                .i_pos   (w_cell_pos),
                .i_val   (w_cell_val),
                .i_left  (w_left),
                .i_right (w_right),
                .o_data  (w_data[g]),
                .o_hit   (w_hit[g])
            );
            assign w_match[g] = w_hit[g] && (CW'(g) < r_count);
        end
    endgenerate

    olirs_find_tree #(
        .CAPACITY (CAPACITY),
        .IW       (IW)
    ) u_tree (
        .i_clk   (i_clk),
        .i_match (w_match),
        .o_found (w_found),
        .o_idx   (w_found_idx)
    );

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        n_key       = r_key;
        w_ctrl      = '0;
        if (w_in_acc) begin
            n_out.found_position = 8'd0;
            case (i_in_item.opcode)
                olirs_pkg::OpInsert: begin
                    n_out_valid = 1'b1;
                    if (r_count >= CapCount) begin
                        n_out.status      = olirs_pkg::StFull;
                        n_out.entry_count = 9'(r_count);
                    end else begin
                        w_ctrl.ins        = 1'b1;
                        n_count           = CW'(r_count + 1'b1);
                        n_out.status      = olirs_pkg::StOk;
                        n_out.entry_count = 9'(r_count + 1'b1);
                    end
                end
                olirs_pkg::OpRemove: begin
                    n_out_valid = 1'b1;
                    if (w_pos_raw >= w_cnt_ext) begin
                        n_out.status      = olirs_pkg::StRange;
                        n_out.entry_count = 9'(r_count);
                    end else begin
                        w_ctrl.rem        = 1'b1;
                        n_count           = CW'(r_count - 1'b1);
                        n_out.status      = olirs_pkg::StOk;
                        n_out.entry_count = 9'(r_count - 1'b1);
                    end
                end
                olirs_pkg::OpFind: begin
                    n_out       = r_out;
                    n_state     = StSearch;
                    n_cnt       = '0;
                    n_key       = w_in_val;
                end
                olirs_pkg::OpClear: begin
                    n_out_valid       = 1'b1;
                    n_count           = '0;
                    n_out.status      = olirs_pkg::StOk;
                    n_out.entry_count = 9'd0;
                end
                default: begin
                    n_out = r_out;
                end
            endcase
        end
        if (r_state == StSearch) begin
            if (r_cnt != CntW'(Lat)) begin
                n_cnt = CntW'(r_cnt + 1'b1);
            end else if (w_slot) begin
                n_state           = StIdle;
                n_out_valid       = 1'b1;
                n_out.entry_count = 9'(r_count);
                if (w_found) begin
                    n_out.status         = olirs_pkg::StOk;
                    n_out.found_position = 8'(w_found_idx);
                end else begin
                    n_out.status         = olirs_pkg::StNotFound;
                    n_out.found_position = 8'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= StIdle;
            r_cnt       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_key <= n_key;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CapCount)
        else $error("entry count above capacity");

    a_no_accept_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == StSearch) |-> !o_in_ready)
        else $error("item taken during find");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_item.opcode == olirs_pkg::OpInsert && r_count < CapCount)
        |=> (r_count == CW'($past(r_count) + 1'b1)))
        else $error("insert did not grow list");

    a_search_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == StSearch && $past(r_state) == StSearch) |-> $stable(r_count))
        else $error("count changed during find");
`endif

endmodule
